>>> sv/puf_pkg.sv
// ----------------------------------------------------------------------------
// puf_pkg
// Shared types and constants of the percolation union-find core.
// ----------------------------------------------------------------------------
`default_nettype none

package puf_pkg;

    localparam int SITES_DEF = 1024;
    localparam int SITE_W    = 10;
    localparam int CFG_W     = 11;
    localparam int MEAN_W    = 28;
    localparam int SIZE_W    = 11;

    localparam logic [MEAN_W-1:0] MEAN_MAX      = {MEAN_W{1'b1}};
    localparam logic [CFG_W-1:0]  CFG_RESET     = 11'd1024;
    localparam int                RESET_SITES   = 1024;

    // bond request after classification
    typedef struct packed {
        logic [SITE_W-1:0] site_a;
        logic [SITE_W-1:0] site_b;
        logic              ok;
    } bond_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_RD_A,
        BK_EV_A,
        BK_RD_B,
        BK_EV_B,
        BK_JOIN,
        BK_WR_BIG,
        BK_WR_SMALL,
        BK_SQUARE,
        BK_PREP,
        BK_DIV,
        BK_FIN,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

>>> sv/puf_if.sv
// ----------------------------------------------------------------------------
// puf_if
// Channel interfaces: bond requests, configuration writes and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface puf_bond_if import puf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SITE_W-1:0] site_a;
    logic [SITE_W-1:0] site_b;
    modport source (output valid, site_a, site_b, input ready);
    modport sink   (input valid, site_a, site_b, output ready);
endinterface

interface puf_cfg_if import puf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] sites_in_use;
    modport source (output valid, sites_in_use, input ready);
    modport sink   (input valid, sites_in_use, output ready);
endinterface

interface puf_result_if import puf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MEAN_W-1:0] mean_size;
    logic [SIZE_W-1:0] largest_size;
    logic [SITE_W-1:0] largest_root_out;
    logic              merged;
    modport source (output valid, mean_size, largest_size, largest_root_out, merged,
                    input ready);
    modport sink   (input valid, mean_size, largest_size, largest_root_out, merged,
                    output ready);
endinterface

`default_nettype wire

>>> sv/puf_front.sv
// ----------------------------------------------------------------------------
// puf_front
// Holds the site count register, accepts bonds and marks out-of-range ones.
// ----------------------------------------------------------------------------
`default_nettype none

module puf_front
    import puf_pkg::*;
#(
    parameter int SITES = SITES_DEF,
    localparam int NW = $clog2(SITES) + 1
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    puf_bond_if.sink         bond,
    puf_cfg_if.sink          cfg,
    input  wire logic        clear_done,
    output logic             push_valid,
    input  wire logic        push_ready,
    output bond_t            push_data,
    output logic [NW-1:0]    n_eff
);

    localparam int CW = (NW > CFG_W) ? NW : CFG_W;

    logic [CFG_W-1:0] sites_reg;
    logic [CFG_W-1:0] sites_next;
    logic [CW-1:0]    n_wide;

    always_comb
    begin
        sites_next = sites_reg;
        if (cfg.valid)
        begin
            sites_next = cfg.sites_in_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sites_reg <= CFG_RESET;
        end
        else
        begin
            sites_reg <= sites_next;
        end
    end

    // clamp the site count into 1..SITES
    always_comb
    begin
        if (sites_reg == '0)
        begin
            n_wide = CW'(1);
        end
        else if (CW'(sites_reg) > CW'(SITES))
        begin
            n_wide = CW'(SITES);
        end
        else
        begin
            n_wide = CW'(sites_reg);
        end
    end

    assign n_eff      = NW'(n_wide);
    assign cfg.ready  = 1'b1;
    assign bond.ready = push_ready && clear_done;
    assign push_valid = bond.valid && clear_done;

    always_comb
    begin
        push_data.site_a = bond.site_a;
        push_data.site_b = bond.site_b;
        push_data.ok     = (CW'(bond.site_a) < n_wide) && (CW'(bond.site_b) < n_wide);
    end

endmodule

`default_nettype wire

>>> sv/puf_fifo.sv
// ----------------------------------------------------------------------------
// puf_fifo
// Two-entry queue of classified bonds between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module puf_fifo
    import puf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire bond_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output bond_t      out_data
);

    bond_t      slot_reg [2];
    logic       wr_reg;
    logic       wr_next;
    logic       rd_reg;
    logic       rd_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next    = push ? !wr_reg : wr_reg;
        rd_next    = pop ? !rd_reg : rd_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/puf_back.sv
// ----------------------------------------------------------------------------
// puf_back
// Union-find table, root walks, merge, sum update and mean divider.
// ----------------------------------------------------------------------------
`default_nettype none

module puf_back
    import puf_pkg::*;
#(
    parameter int SITES = SITES_DEF,
    localparam int NW = $clog2(SITES) + 1
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pop_valid,
    output logic             pop_ready,
    input  wire bond_t       pop_data,
    input  wire logic [NW-1:0] n_eff,
    output logic             clear_done,
    puf_result_if.source     result
);

    localparam int LOG   = $clog2(SITES);
    localparam int EW    = LOG + 2;
    localparam int SW    = 2 * LOG + 1;
    localparam int PW    = 2 * NW;
    localparam int QW    = SW + 8;
    localparam int CNT_W = $clog2(QW + 1);
    localparam int MW    = (QW > MEAN_W) ? QW : MEAN_W;
    localparam int RSUM  = (SITES < RESET_SITES) ? SITES : RESET_SITES;

    logic [EW-1:0] table_mem [SITES];
    logic [EW-1:0] rdata_reg;
    logic          we;
    logic [LOG-1:0] waddr;
    logic [EW-1:0] wdata;

    back_state_t    state_reg, state_next;
    logic [LOG-1:0] clr_reg, clr_next;
    logic [LOG-1:0] cur_reg, cur_next;
    logic [NW-1:0]  steps_reg, steps_next;
    logic [LOG-1:0] bsite_reg, bsite_next;
    logic [LOG-1:0] ra_reg, ra_next;
    logic [LOG-1:0] rb_reg, rb_next;
    logic [EW-1:0]  va_reg, va_next;
    logic [EW-1:0]  vb_reg, vb_next;
    logic [LOG-1:0] big_reg, big_next;
    logic [LOG-1:0] small_reg, small_next;
    logic [NW-1:0]  tot_reg, tot_next;
    logic [PW-1:0]  prod_reg, prod_next;
    logic [SW-1:0]  sq_reg, sq_next;
    logic [SW-1:0]  s2_reg, s2_next;
    logic [LOG-1:0] lroot_reg, lroot_next;
    logic [NW-1:0]  lsize_reg, lsize_next;
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic           merged_reg, merged_next;
    logic [QW-1:0]  dq_reg, dq_next;
    logic [NW:0]    rem_reg, rem_next;
    logic [NW-1:0]  den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           res_valid_reg, res_valid_next;
    logic [MEAN_W-1:0] res_mean_reg, res_mean_next;
    logic [SIZE_W-1:0] res_size_reg, res_size_next;
    logic [SITE_W-1:0] res_root_reg, res_root_next;
    logic           res_merged_reg, res_merged_next;

    logic           link_ok;
    logic           b_is_big;
    logic [EW-1:0]  vbig;
    logic [EW-1:0]  vsmall;
    logic [NW-1:0]  sbig;
    logic [NW-1:0]  ssmall;
    logic [SW-1:0]  num;
    logic [NW:0]    trial;
    logic [MW-1:0]  qx;

    function automatic logic [NW-1:0] size_of(input logic [EW-1:0] v);
        logic [EW-1:0] neg;
        neg = ~v + EW'(1);
        return v[EW-1] ? NW'(neg) : '0;
    endfunction

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            table_mem[waddr] <= wdata;
        end
        rdata_reg <= table_mem[cur_reg];
    end

    // follow the link only from a non-root entry that points inside the table
    assign link_ok  = !rdata_reg[EW-1] && (steps_reg < NW'(SITES))
                      && (rdata_reg < EW'(SITES));
    assign b_is_big = ($signed(vb_reg) < $signed(va_reg));
    assign vbig     = b_is_big ? vb_reg : va_reg;
    assign vsmall   = b_is_big ? va_reg : vb_reg;
    assign sbig     = size_of(vbig);
    assign ssmall   = size_of(vsmall);
    assign num      = (s2_reg >= sq_reg) ? (s2_reg - sq_reg) : '0;
    assign trial    = {rem_reg[NW-1:0], dq_reg[QW-1]};
    assign qx       = MW'(dq_reg);
    assign clear_done = (state_reg != BK_CLEAR);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        bsite_next      = bsite_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        va_next         = va_reg;
        vb_next         = vb_reg;
        big_next        = big_reg;
        small_next      = small_reg;
        tot_next        = tot_reg;
        prod_next       = prod_reg;
        sq_next         = sq_reg;
        s2_next         = s2_reg;
        lroot_next      = lroot_reg;
        lsize_next      = lsize_reg;
        mean_next       = mean_reg;
        merged_next     = merged_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        cnt_next        = cnt_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_mean_next   = res_mean_reg;
        res_size_next   = res_size_reg;
        res_root_next   = res_root_reg;
        res_merged_next = res_merged_reg;
        we              = 1'b0;
        waddr           = clr_reg;
        wdata           = {EW{1'b1}};
        pop_ready       = 1'b0;

        unique case (state_reg)
            BK_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + LOG'(1);
                if (clr_reg == LOG'(SITES - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    merged_next = 1'b0;
                    cur_next    = LOG'(pop_data.site_a);
                    bsite_next  = LOG'(pop_data.site_b);
                    steps_next  = '0;
                    state_next  = pop_data.ok ? BK_RD_A : BK_DONE;
                end
            end
            BK_RD_A:
            begin
                state_next = BK_EV_A;
            end
            BK_EV_A:
            begin
                if (link_ok)
                begin
                    cur_next   = LOG'(rdata_reg);
                    steps_next = steps_reg + NW'(1);
                    state_next = BK_RD_A;
                end
                else
                begin
                    ra_next    = cur_reg;
                    va_next    = rdata_reg;
                    cur_next   = bsite_reg;
                    steps_next = '0;
                    state_next = BK_RD_B;
                end
            end
            BK_RD_B:
            begin
                state_next = BK_EV_B;
            end
            BK_EV_B:
            begin
                if (link_ok)
                begin
                    cur_next   = LOG'(rdata_reg);
                    steps_next = steps_reg + NW'(1);
                    state_next = BK_RD_B;
                end
                else
                begin
                    rb_next    = cur_reg;
                    vb_next    = rdata_reg;
                    state_next = BK_JOIN;
                end
            end
            BK_JOIN:
            begin
                if (ra_reg == rb_reg)
                begin
                    state_next = BK_DONE;
                end
                else
                begin
                    big_next   = b_is_big ? rb_reg : ra_reg;
                    small_next = b_is_big ? ra_reg : rb_reg;
                    tot_next   = sbig + ssmall;
                    prod_next  = PW'(sbig) * PW'(ssmall);
                    state_next = BK_WR_BIG;
                end
            end
            BK_WR_BIG:
            begin
                we         = 1'b1;
                waddr      = big_reg;
                wdata      = ~EW'(tot_reg) + EW'(1);
                state_next = BK_WR_SMALL;
            end
            BK_WR_SMALL:
            begin
                we          = 1'b1;
                waddr       = small_reg;
                wdata       = EW'(big_reg);
                // (sb+ss)^2 - sb^2 - ss^2
                s2_next     = s2_reg + (SW'(prod_reg) << 1);
                merged_next = 1'b1;
                if (lroot_reg == small_reg || lroot_reg == big_reg || tot_reg > lsize_reg)
                begin
                    lroot_next = big_reg;
                    lsize_next = tot_reg;
                end
                state_next = BK_SQUARE;
            end
            BK_SQUARE:
            begin
                sq_next    = SW'(lsize_reg) * SW'(lsize_reg);
                state_next = BK_PREP;
            end
            BK_PREP:
            begin
                if (lsize_reg >= n_eff)
                begin
                    mean_next  = '0;
                    state_next = BK_DONE;
                end
                else
                begin
                    dq_next    = {num, 8'h00};
                    rem_next   = '0;
                    den_next   = n_eff - lsize_reg;
                    cnt_next   = '0;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = trial - {1'b0, den_reg};
                    dq_next  = {dq_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    dq_next  = {dq_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QW - 1))
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                mean_next  = (qx > MW'(MEAN_MAX)) ? MEAN_MAX : qx[MEAN_W-1:0];
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_mean_next   = mean_reg;
                    res_size_next   = SIZE_W'(lsize_reg);
                    res_root_next   = SITE_W'(lroot_reg);
                    res_merged_next = merged_reg;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            clr_reg        <= '0;
            s2_reg         <= SW'(RSUM);
            lroot_reg      <= '0;
            lsize_reg      <= NW'(1);
            mean_reg       <= '0;
            merged_reg     <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            s2_reg         <= s2_next;
            lroot_reg      <= lroot_next;
            lsize_reg      <= lsize_next;
            mean_reg       <= mean_next;
            merged_reg     <= merged_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        bsite_reg      <= bsite_next;
        ra_reg         <= ra_next;
        rb_reg         <= rb_next;
        va_reg         <= va_next;
        vb_reg         <= vb_next;
        big_reg        <= big_next;
        small_reg      <= small_next;
        tot_reg        <= tot_next;
        prod_reg       <= prod_next;
        sq_reg         <= sq_next;
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        den_reg        <= den_next;
        cnt_reg        <= cnt_next;
        res_mean_reg   <= res_mean_next;
        res_size_reg   <= res_size_next;
        res_root_reg   <= res_root_next;
        res_merged_reg <= res_merged_next;
    end

    assign result.valid            = res_valid_reg;
    assign result.mean_size        = res_mean_reg;
    assign result.largest_size     = res_size_reg;
    assign result.largest_root_out = res_root_reg;
    assign result.merged           = res_merged_reg;

endmodule

`default_nettype wire

>>> sv/percolation_union_find_core.sv
// ----------------------------------------------------------------------------
// percolation_union_find_core
// Bond percolation with a union-find table and cluster size statistics.
// ----------------------------------------------------------------------------
// Channels: bond takes one request per activated bond (site_a, site_b);
// result returns one item per request (mean_size, largest_size,
// largest_root_out, merged); cfg writes sites_in_use, and the user must
// do so only while the core is idle, as the core leaves this unchecked.
// All handshakes complete on a rising clk edge with valid and ready high.
// Each request walks both parent chains through the table, reading each
// entry and then evaluating it, merges the two roots, updates the sum and
// largest cluster, and runs the bit-serial mean divider before reporting.
// A merge that leaves one cluster over all sites in use skips the divider.
// Bonds that join no clusters skip the merge and the divider; bonds that
// touch a site out of use skip the walk as well.
// A two-entry queue lets the front take requests while the back works, and
// the result register holds a finished item while the receiver stalls; the
// back then waits before starting the next request.
// After rst_n the table is swept to all roots of size one, one entry per
// cycle; bond.ready stays low until the sweep ends.
// ----------------------------------------------------------------------------
`default_nettype none

module percolation_union_find_core
    import puf_pkg::*;
#(
    parameter int SITES = SITES_DEF
)(
    input  wire logic    clk,
    input  wire logic    rst_n,
    puf_bond_if.sink     bond,
    puf_cfg_if.sink      cfg,
    puf_result_if.source result
);

    localparam int NW = $clog2(SITES) + 1;

    logic          push_valid;
    logic          push_ready;
    bond_t         push_data;
    logic          pop_valid;
    logic          pop_ready;
    bond_t         pop_data;
    logic          clear_done;
    logic [NW-1:0] n_eff;

    puf_front #(.SITES(SITES)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bond       (bond),
        .cfg        (cfg),
        .clear_done (clear_done),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .n_eff      (n_eff)
    );

    puf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    puf_back #(.SITES(SITES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .n_eff      (n_eff),
        .clear_done (clear_done),
        .result     (result)
    );

endmodule

`default_nettype wire
